[src/epm_pkg.sv]
// Shared constants, command codes and cell control type for the pattern matcher.
package epm_pkg;

  localparam int PAT_MAX  = 64;
  localparam int TEXT_MAX = 1048576;

  localparam int LEN_W = $clog2(PAT_MAX + 1);
  localparam int IDX_W = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
  localparam int CNT_W = 21;
  localparam int POS_W = 21;
  localparam int SYM_W = 8;
  localparam int CMD_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PATTERN = 2'd0,
    CMD_TEXT    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef struct packed {
    logic             text_en;
    logic             clear;
    logic [SYM_W-1:0] symbol;
  } cell_ctrl_t;

endpackage

[src/epm_cell.sv]
// One matcher cell: holds a pattern byte and a partial-match bit, passes the bit onward.
module epm_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  epm_pkg::cell_ctrl_t    ctrl,
  input  logic                   pat_we,
  input  logic                   prev_hit,
  output logic                   hit_nxt,
  output logic                   hit
);

  logic [epm_pkg::SYM_W-1:0] pat_r;
  logic                      hit_r;

  assign hit_nxt = prev_hit && (ctrl.symbol == pat_r);
  assign hit     = hit_r;

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_r <= ctrl.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctrl.clear) begin
      hit_r <= 1'b0;
    end else if (ctrl.text_en) begin
      hit_r <= hit_nxt;
    end
  end

endmodule

[src/epm_skid.sv]
// Output register with a skid entry for match positions.
module epm_skid (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       res_valid,
  input  logic [epm_pkg::POS_W-1:0]  res_pos,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [epm_pkg::POS_W-1:0]  out_pos,
  output logic                       full
);

  logic                      out_valid_r;
  logic [epm_pkg::POS_W-1:0] out_pos_r;
  logic                      skid_valid_r;
  logic [epm_pkg::POS_W-1:0] skid_pos_r;
  logic                      room;

  assign room      = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_pos   = out_pos_r;
  assign full      = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (room) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid && !skid_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (room) begin
      if (skid_valid_r) begin
        out_pos_r <= skid_pos_r;
      end else if (res_valid) begin
        out_pos_r <= res_pos;
      end
    end else if (res_valid && !skid_valid_r) begin
      skid_pos_r <= res_pos;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> !skid_valid_r)
    else $error("skid entry did not drain on a taken beat");

endmodule

[src/exact_pattern_match_positions_core.sv]
// Top level of the exact pattern matcher: command decode, cell chain and output stage.
//
// Input channel (in_valid / in_stall, in_command, in_symbol): one beat per
// command. Append-pattern stores a byte and forgets all text; text presents
// one text byte; restart clears pattern and text. Command code 3 is ignored.
// Result channel (out_valid / out_stall, out_match_start): one beat for each
// text byte that completes an occurrence, carrying the 1-based start position.
// Overlapping occurrences each give a beat; an empty pattern matches every
// text byte; a pattern longer than the cell chain suppresses all results.
// The text byte is broadcast to a chain of cells, each holding one pattern
// byte and a partial-match bit handed to its right neighbor on each text byte.
// Throughput: one beat per cycle, any command mix, while in_stall is low.
// A result is registered into the output register, or into the skid entry
// while the output register holds a stalled result.
// When the receiver stalls, the result holds and one more result is caught
// in a skid entry; in_stall rises only while that entry is occupied.
// Synchronous reset empties pattern, text and output stage; no clearing pass.
module exact_pattern_match_positions_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [epm_pkg::CMD_W-1:0]   in_command,
  input  logic [epm_pkg::SYM_W-1:0]   in_symbol,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [epm_pkg::POS_W-1:0]   out_match_start
);

  localparam int PM = epm_pkg::PAT_MAX;
  localparam int LW = epm_pkg::LEN_W;
  localparam int IW = epm_pkg::IDX_W;
  localparam int CW = epm_pkg::CNT_W;
  localparam int PW = epm_pkg::POS_W;

  logic                 accept;
  logic                 pat_acc;
  logic                 txt_acc;
  logic                 rst_acc;
  logic                 pat_full;
  epm_pkg::cell_ctrl_t  ctrl;
  logic [PM-1:0]        pat_we;
  logic [PM-1:0]        hit_nxt;
  logic [PM-1:0]        hit_q;

  logic [LW-1:0]        len_r;
  logic [LW-1:0]        len_nxt;
  logic                 ovf_r;
  logic                 ovf_nxt;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic [CW-1:0]        count_inc;

  logic [LW-1:0]        len_m1;
  logic                 hit;
  logic                 res_valid;
  logic [PW-1:0]        res_pos;
  logic                 skid_full;

  assign accept   = in_valid && !skid_full;
  assign in_stall = skid_full;
  assign pat_full = (len_r == LW'(PM));

  always_comb begin
    pat_acc = 1'b0;
    txt_acc = 1'b0;
    rst_acc = 1'b0;
    if (accept) begin
      unique case (in_command)
        epm_pkg::CMD_PATTERN: pat_acc = 1'b1;
        epm_pkg::CMD_TEXT:    txt_acc = 1'b1;
        epm_pkg::CMD_RESTART: rst_acc = 1'b1;
        default:              ;
      endcase
    end
  end

  always_comb begin
    ctrl.text_en = txt_acc;
    ctrl.clear   = pat_acc || rst_acc;
    ctrl.symbol  = in_symbol;
  end

  genvar g;
  generate
    for (g = 0; g < PM; g++) begin : g_cell
      logic prev_hit;
      if (g == 0) begin : g_first
        assign prev_hit = 1'b1;
      end else begin : g_rest
        assign prev_hit = hit_q[g-1];
      end
      assign pat_we[g] = pat_acc && !pat_full && (len_r[IW-1:0] == IW'(g));
      epm_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .pat_we   (pat_we[g]),
        .prev_hit (prev_hit),
        .hit_nxt  (hit_nxt[g]),
        .hit      (hit_q[g])
      );
    end
  endgenerate

  always_comb begin
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    count_inc = (count_r == CW'(epm_pkg::TEXT_MAX)) ? count_r : count_r + CW'(1);
    count_nxt = count_r;
    if (pat_acc) begin
      if (pat_full) begin
        ovf_nxt = 1'b1;
      end else begin
        len_nxt = len_r + LW'(1);
      end
      count_nxt = '0;
    end else if (rst_acc) begin
      len_nxt   = '0;
      ovf_nxt   = 1'b0;
      count_nxt = '0;
    end else if (txt_acc) begin
      count_nxt = count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      ovf_r   <= 1'b0;
      count_r <= '0;
    end else begin
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
      count_r <= count_nxt;
    end
  end

  assign len_m1    = len_r - LW'(1);
  assign hit       = (len_r == '0) ? 1'b1 : hit_nxt[len_m1[IW-1:0]];
  assign res_valid = txt_acc && !ovf_r && hit;
  assign res_pos   = (len_r == '0) ? PW'(count_inc)
                   : PW'(count_inc - CW'(len_r) + CW'(1));

  epm_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_pos   (res_pos),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_pos   (out_match_start),
    .full      (skid_full)
  );

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(PM))
    else $error("pattern length beyond cell count");

  a_clear_text: assert property (@(posedge clk) disable iff (!rst_n)
    (pat_acc || rst_acc) |=> (count_r == '0) && (hit_q == '0))
    else $error("text history not cleared");

  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (pat_acc && pat_full) |=> ovf_r && (len_r == LW'(PM)))
    else $error("overflow mark not set on excess pattern byte");

endmodule

[sim/tb_exact_pattern_match_positions_core.sv]
// Self-checking testbench for the exact pattern matcher with a match-position scoreboard.
`timescale 1ns / 1ps

module tb_exact_pattern_match_positions_core;

  localparam logic [epm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  class match_tracker;
    logic [epm_pkg::SYM_W-1:0] pat_bytes [epm_pkg::PAT_MAX];
    logic [epm_pkg::SYM_W-1:0] recent [epm_pkg::PAT_MAX];
    int pat_len;
    bit overflow;
    int head;
    int text_seen;
    logic [epm_pkg::POS_W-1:0] due_starts [$];
    int mismatches;

    function new();
      pat_len = 0;
      overflow = 1'b0;
      head = 0;
      text_seen = 0;
      mismatches = 0;
    endfunction

    function void note_command(logic [epm_pkg::CMD_W-1:0] cmd,
                               logic [epm_pkg::SYM_W-1:0] sym);
      bit hit;
      int k;
      case (cmd)
        epm_pkg::CMD_PATTERN: begin
          if (pat_len < epm_pkg::PAT_MAX) begin
            pat_bytes[pat_len] = sym;
            pat_len++;
          end else begin
            overflow = 1'b1;
          end
          text_seen = 0;
        end
        epm_pkg::CMD_RESTART: begin
          pat_len = 0;
          overflow = 1'b0;
          text_seen = 0;
        end
        epm_pkg::CMD_TEXT: begin
          head = (head + 1) % epm_pkg::PAT_MAX;
          recent[head] = sym;
          if (text_seen < epm_pkg::TEXT_MAX) text_seen++;
          if (!overflow && text_seen >= pat_len) begin
            hit = 1'b1;
            for (k = 0; k < pat_len && hit; k++) begin
              if (recent[(head - k + epm_pkg::PAT_MAX) % epm_pkg::PAT_MAX]
                  !== pat_bytes[pat_len - 1 - k]) hit = 1'b0;
            end
            if (hit) begin
              if (pat_len == 0) due_starts.push_back(epm_pkg::POS_W'(text_seen));
              else due_starts.push_back(epm_pkg::POS_W'(text_seen - pat_len + 1));
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_start(logic [epm_pkg::POS_W-1:0] got);
      logic [epm_pkg::POS_W-1:0] want;
      if (due_starts.size() == 0) begin
        if (mismatches < 10) $display("%0t: unexpected match_start %0d", $time, got);
        mismatches++;
      end else begin
        want = due_starts.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display("%0t: match_start expected %0d, got %0d", $time, want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [epm_pkg::CMD_W-1:0] in_command = '0;
  logic [epm_pkg::SYM_W-1:0] in_symbol = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [epm_pkg::POS_W-1:0] out_match_start;

  match_tracker tracker;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int beats_sent = 0;

  exact_pattern_match_positions_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_symbol(in_symbol),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_match_start(out_match_start)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) tracker.check_start(out_match_start);
  end

  // Call at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send(logic [epm_pkg::CMD_W-1:0] cmd, logic [epm_pkg::SYM_W-1:0] sym);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_symbol <= sym;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.note_command(cmd, sym);
    if (cmd != CMD_UNUSED) beats_sent++;
    @(negedge clk);
  endtask

  function automatic logic [epm_pkg::SYM_W-1:0] pick(logic [epm_pkg::SYM_W-1:0] a,
                                                     logic [epm_pkg::SYM_W-1:0] b,
                                                     bit wide);
    if (wide) return epm_pkg::SYM_W'($urandom);
    return ($urandom_range(1) != 0) ? a : b;
  endfunction

  task automatic pattern_run(int plen, int tlen);
    logic [epm_pkg::SYM_W-1:0] letter_a;
    logic [epm_pkg::SYM_W-1:0] letter_b;
    logic [epm_pkg::SYM_W-1:0] s;
    logic [epm_pkg::SYM_W-1:0] pat [$];
    bit wide;
    int emitted;
    int span;
    letter_a = epm_pkg::SYM_W'($urandom);
    letter_b = ($urandom_range(3) == 0) ? letter_a : epm_pkg::SYM_W'($urandom);
    wide = ($urandom_range(4) == 0);
    if ($urandom_range(4) != 0) send(epm_pkg::CMD_RESTART, epm_pkg::SYM_W'($urandom));
    repeat (plen) begin
      s = pick(letter_a, letter_b, wide);
      pat.push_back(s);
      send(epm_pkg::CMD_PATTERN, s);
    end
    emitted = 0;
    if (plen > 0) begin
      foreach (pat[i]) send(epm_pkg::CMD_TEXT, pat[i]);
      emitted = plen;
    end
    while (emitted < tlen) begin
      case ($urandom_range(9))
        0: begin
          // break the sequence: a pattern byte mid-text drops the text
          s = pick(letter_a, letter_b, wide);
          pat.push_back(s);
          send(epm_pkg::CMD_PATTERN, s);
        end
        1, 2, 3: begin
          if (pat.size() > 0) begin
            span = $urandom_range(1, pat.size());
            for (int i = 0; i < span; i++) send(epm_pkg::CMD_TEXT, pat[i]);
            emitted += span;
          end else begin
            send(epm_pkg::CMD_TEXT, pick(letter_a, letter_b, wide));
            emitted++;
          end
        end
        default: begin
          send(epm_pkg::CMD_TEXT, pick(letter_a, letter_b, wide));
          emitted++;
        end
      endcase
    end
  endtask

  task automatic random_phase(int n);
    int stop_at;
    int plen;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      if ($urandom_range(9) == 0) begin
        send(epm_pkg::CMD_W'($urandom_range(3)), epm_pkg::SYM_W'($urandom));
      end else begin
        plen = ($urandom_range(2) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
        pattern_run(plen, $urandom_range(plen, 3 * plen + 6));
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send(epm_pkg::CMD_TEXT, 8'h00);
    send(epm_pkg::CMD_TEXT, 8'hFF);
    send(CMD_UNUSED, 8'hA5);
    send(epm_pkg::CMD_TEXT, 8'h7E);
    send(epm_pkg::CMD_PATTERN, 8'h00);
    send(epm_pkg::CMD_PATTERN, 8'hFF);
    send(epm_pkg::CMD_PATTERN, 8'h00);
    send(epm_pkg::CMD_TEXT, 8'h00);
    send(epm_pkg::CMD_TEXT, 8'hFF);
    send(epm_pkg::CMD_TEXT, 8'h00);
    send(epm_pkg::CMD_TEXT, 8'hFF);
    send(epm_pkg::CMD_TEXT, 8'h00);
    send(CMD_UNUSED, 8'hFF);
    send(epm_pkg::CMD_TEXT, 8'hFF);
    send(epm_pkg::CMD_TEXT, 8'h00);
    send(epm_pkg::CMD_PATTERN, 8'h80);
    send(epm_pkg::CMD_TEXT, 8'h00);
    send(epm_pkg::CMD_TEXT, 8'hFF);
    send(epm_pkg::CMD_TEXT, 8'h00);
    send(epm_pkg::CMD_TEXT, 8'h80);
    send(epm_pkg::CMD_RESTART, 8'hFF);
    send(epm_pkg::CMD_PATTERN, 8'h01);
    send(epm_pkg::CMD_TEXT, 8'h01);
    send(epm_pkg::CMD_TEXT, 8'h01);
    send(epm_pkg::CMD_RESTART, 8'h00);

    pattern_run(epm_pkg::PAT_MAX, epm_pkg::PAT_MAX + 8);
    send(epm_pkg::CMD_RESTART, 8'h00);
    pattern_run(epm_pkg::PAT_MAX + 1, 12);
    random_phase(25);

    send_idle_pct = 78;
    random_phase(25);

    send_idle_pct = 0;
    recv_stall_pct = 78;
    random_phase(25);

    send_idle_pct = 12;
    recv_stall_pct = 12;
    random_phase(25);

    in_valid <= 1'b0;
    while (tracker.due_starts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
